// ===== hdl/mcsh_pkg.sv =====
// Shared widths, constants and beat types for the swept circle versus segment core.
package mcsh_pkg;

  localparam int COORD_BITS = 16;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int DIST_BITS  = 22;
  localparam int DIFF_BITS  = COORD_BITS + 2;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef struct packed {
    coord_t              start_x;
    coord_t              start_y;
    coord_t              move_x;
    coord_t              move_y;
    logic [RAD_BITS-1:0] radius;
    coord_t              seg_a_x;
    coord_t              seg_a_y;
    coord_t              seg_b_x;
    coord_t              seg_b_y;
  } query_t;

  typedef struct packed {
    logic                 paths_cross;
    logic [DIST_BITS-1:0] min_distance;
    logic                 hit;
  } result_t;

endpackage

// ===== hdl/mcsh_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module mcsh_div #(
  parameter int QW = 44,
  parameter int VW = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QW+VW-1:0] dividend,
  input  logic [VW-1:0]    divisor,
  output logic             out_valid,
  output logic [QW-1:0]    quotient,
  output logic             overflow
);

  logic [VW-1:0] rem  [QW];
  logic [QW-1:0] low  [QW];
  logic [VW-1:0] dvs  [QW];
  logic [QW-1:0] quo  [QW+1];
  logic          ovf  [QW+1];
  logic [QW:0]   vld;

  logic [VW:0]   trial    [QW];
  logic [VW:0]   diff     [QW];
  logic          ge       [QW];
  logic [VW-1:0] rem_next [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k]    = {rem[k], low[k][QW-1]};
      diff[k]     = trial[k] - {1'b0, dvs[k]};
      ge[k]       = trial[k] >= {1'b0, dvs[k]};
      rem_next[k] = ge[k] ? diff[k][VW-1:0] : trial[k][VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient wider than QW bits when the top part already reaches the divisor
      rem[0] <= dividend[QW+VW-1:QW];
      low[0] <= dividend[QW-1:0];
      dvs[0] <= divisor;
      quo[0] <= '0;
      ovf[0] <= dividend[QW+VW-1:QW] >= divisor;
      for (int k = 0; k < QW; k++) begin
        quo[k+1] <= {quo[k][QW-2:0], ge[k]};
        ovf[k+1] <= ovf[k];
      end
      for (int k = 0; k < QW - 1; k++) begin
        rem[k+1] <= rem_next[k];
        low[k+1] <= {low[k][QW-2:0], 1'b0};
        dvs[k+1] <= dvs[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = quo[QW];
  assign overflow  = ovf[QW];

endmodule

// ===== hdl/mcsh_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module mcsh_sqrt #(
  parameter int XW = 44
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [XW-1:0]   radicand,
  output logic            out_valid,
  output logic [XW/2-1:0] root
);

  localparam int SQ = XW / 2;
  localparam int RW = SQ + 2;

  logic [RW-1:0] rem  [SQ];
  logic [XW-1:0] xr   [SQ];
  logic [SQ-1:0] rt   [SQ+1];
  logic [SQ:0]   vld;

  logic [RW+1:0] rr       [SQ];
  logic [RW+1:0] trial    [SQ];
  logic [RW+1:0] diff     [SQ];
  logic          ge       [SQ];
  logic [RW-1:0] rem_next [SQ];

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      rr[k]       = {rem[k], xr[k][XW-1:XW-2]};
      trial[k]    = {2'b00, rt[k], 2'b01};
      diff[k]     = rr[k] - trial[k];
      ge[k]       = rr[k] >= trial[k];
      rem_next[k] = ge[k] ? diff[k][RW-1:0] : rr[k][RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQ-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      xr[0]  <= radicand;
      rt[0]  <= '0;
      for (int k = 0; k < SQ; k++) begin
        rt[k+1] <= {rt[k][SQ-2:0], ge[k]};
      end
      for (int k = 0; k < SQ - 1; k++) begin
        rem[k+1] <= rem_next[k];
        xr[k+1]  <= {xr[k][XW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[SQ];
  assign root      = rt[SQ];

endmodule

// ===== hdl/moving_circle_segment_hit_core.sv =====
// Swept circle versus static segment: crossing test, shortest distance and hit flag.
//
//  channel  direction  handshake                     beat
//  query    in         query_valid / query_stall     query_t  (start, move, radius, A, B)
//  result   out        result_valid / result_stall   result_t (paths_cross, min_distance, hit)
//
// One beat per cycle sustained while result_stall is low; the divider is bit-per-stage
// (XW+1 stages) and so is the square root (XW/2+1 stages).
// Reset clears only the valid bits; payload registers carry no reset.
// A stalled result freezes the whole pipeline; query_stall follows it in the same cycle.
module moving_circle_segment_hit_core #(
  parameter int FRAC_BITS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_stall,
  input  mcsh_pkg::query_t query,
  output logic             result_valid,
  input  logic             result_stall,
  output mcsh_pkg::result_t result
);
  import mcsh_pkg::*;

  localparam int PW   = 2 * DIFF_BITS;
  localparam int HW   = PW / 2;
  localparam int SW   = PW + 1;
  localparam int NUMW = 2 * PW;
  localparam int R2W  = 2 * RAD_BITS;
  localparam int XW   = (2 * DIST_BITS > PW + 2 * FRAC_BITS) ? 2 * DIST_BITS
                                                              : PW + 2 * FRAC_BITS;
  localparam int SQW  = XW / 2;
  localparam int DVW  = XW + PW;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    diff_t dx, dy, wx, wy, ex, ey;
  } geo_t;

  typedef struct packed {
    prod_t dxwx, dywy, dxex, dyey, dxwy, dywx, wx2, wy2, ex2, ey2, dx2, dy2;
  } prods_t;

  typedef struct packed {
    logic          perp;
    sum_t          cr;
    logic [PW-1:0] da, db, den;
  } sums_t;

  typedef struct packed {
    logic          perp;
    logic [PW-1:0] mag, emin, den;
  } mags_t;

  typedef struct packed {
    logic          perp;
    logic [PW-1:0] hh, hl, ll, emin, den;
  } parts_t;

  function automatic logic opp(input sum_t s, input sum_t t);
    opp = (s > 0 && t < 0) || (s < 0 && t > 0);
  endfunction

  logic advance;
  logic [6:0] pv;
  logic [1:0] qv;
  logic [3:0] div_valid;

  query_t              q0;
  geo_t                s1_geo  [4];
  logic [RAD_BITS-1:0] s1_r;
  prods_t              s2_prod [4];
  logic [R2W-1:0]      s2_r2, s3_r2, s4_r2, s5_r2, s6_r2;
  sums_t               s3_sum  [4];
  mags_t               s4_mag  [4];
  parts_t              s5_part [4];
  logic                s4_xing, s5_xing, s6_xing;
  logic [NUMW-1:0]     s6_num  [4];
  logic [PW-1:0]       s6_den  [4];

  diff_t p0x, p0y, p1x, p1y, ax, ay, bx, by, mx, my, sx, sy;
  geo_t  geo_next [4];
  sum_t  aa [4], ab [4], crs [4];
  logic [NUMW-1:0] sq [4];

  assign advance     = !(result_valid && result_stall);
  assign query_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
      qv <= '0;
    end else if (advance) begin
      pv <= {pv[5:0], query_valid};
      qv <= {qv[0], div_valid[0]};
    end
  end

  // stage 1: difference vectors for the four point-to-segment tests
  always_comb begin
    p0x = diff_t'(q0.start_x);
    p0y = diff_t'(q0.start_y);
    mx  = diff_t'(q0.move_x);
    my  = diff_t'(q0.move_y);
    p1x = p0x + mx;
    p1y = p0y + my;
    ax  = diff_t'(q0.seg_a_x);
    ay  = diff_t'(q0.seg_a_y);
    bx  = diff_t'(q0.seg_b_x);
    by  = diff_t'(q0.seg_b_y);
    sx  = bx - ax;
    sy  = by - ay;
    geo_next[0] = '{dx: mx, dy: my, wx: ax - p0x, wy: ay - p0y, ex: ax - p1x, ey: ay - p1y};
    geo_next[1] = '{dx: mx, dy: my, wx: bx - p0x, wy: by - p0y, ex: bx - p1x, ey: by - p1y};
    geo_next[2] = '{dx: sx, dy: sy, wx: p0x - ax, wy: p0y - ay, ex: p0x - bx, ey: p0y - by};
    geo_next[3] = '{dx: sx, dy: sy, wx: p1x - ax, wy: p1y - ay, ex: p1x - bx, ey: p1y - by};
  end

  // stage 3: dot products, cross product and squared lengths
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aa[i]  = sum_t'(s2_prod[i].dxwx) + sum_t'(s2_prod[i].dywy);
      ab[i]  = sum_t'(s2_prod[i].dxex) + sum_t'(s2_prod[i].dyey);
      crs[i] = sum_t'(s2_prod[i].dxwy) - sum_t'(s2_prod[i].dywx);
    end
  end

  // stage 6: assemble the squared cross product from its partial products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq[i] = (NUMW'(s5_part[i].hh) << PW) + (NUMW'(s5_part[i].hl) << (HW + 1))
              + NUMW'(s5_part[i].ll);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q0 <= query;

      s1_geo <= geo_next;
      s1_r   <= q0.radius;

      for (int i = 0; i < 4; i++) begin
        s2_prod[i].dxwx <= s1_geo[i].dx * s1_geo[i].wx;
        s2_prod[i].dywy <= s1_geo[i].dy * s1_geo[i].wy;
        s2_prod[i].dxex <= s1_geo[i].dx * s1_geo[i].ex;
        s2_prod[i].dyey <= s1_geo[i].dy * s1_geo[i].ey;
        s2_prod[i].dxwy <= s1_geo[i].dx * s1_geo[i].wy;
        s2_prod[i].dywx <= s1_geo[i].dy * s1_geo[i].wx;
        s2_prod[i].wx2  <= s1_geo[i].wx * s1_geo[i].wx;
        s2_prod[i].wy2  <= s1_geo[i].wy * s1_geo[i].wy;
        s2_prod[i].ex2  <= s1_geo[i].ex * s1_geo[i].ex;
        s2_prod[i].ey2  <= s1_geo[i].ey * s1_geo[i].ey;
        s2_prod[i].dx2  <= s1_geo[i].dx * s1_geo[i].dx;
        s2_prod[i].dy2  <= s1_geo[i].dy * s1_geo[i].dy;
      end
      s2_r2 <= s1_r * s1_r;

      for (int i = 0; i < 4; i++) begin
        // perpendicular only when the projection falls strictly inside
        s3_sum[i].perp <= (aa[i] > 0) && (ab[i] < 0);
        s3_sum[i].cr   <= crs[i];
        s3_sum[i].da   <= s2_prod[i].wx2 + s2_prod[i].wy2;
        s3_sum[i].db   <= s2_prod[i].ex2 + s2_prod[i].ey2;
        s3_sum[i].den  <= s2_prod[i].dx2 + s2_prod[i].dy2;
      end
      s3_r2 <= s2_r2;

      for (int i = 0; i < 4; i++) begin
        s4_mag[i].perp <= s3_sum[i].perp;
        s4_mag[i].mag  <= PW'(s3_sum[i].cr[SW-1] ? -s3_sum[i].cr : s3_sum[i].cr);
        s4_mag[i].emin <= (s3_sum[i].da < s3_sum[i].db) ? s3_sum[i].da : s3_sum[i].db;
        s4_mag[i].den  <= s3_sum[i].den;
      end
      // the four cross products double as the side tests of the crossing check
      s4_xing <= opp(s3_sum[0].cr, s3_sum[1].cr) && opp(s3_sum[2].cr, s3_sum[3].cr);
      s4_r2   <= s3_r2;

      for (int i = 0; i < 4; i++) begin
        s5_part[i].perp <= s4_mag[i].perp;
        s5_part[i].hh   <= s4_mag[i].mag[PW-1:HW] * s4_mag[i].mag[PW-1:HW];
        s5_part[i].hl   <= s4_mag[i].mag[PW-1:HW] * s4_mag[i].mag[HW-1:0];
        s5_part[i].ll   <= s4_mag[i].mag[HW-1:0] * s4_mag[i].mag[HW-1:0];
        s5_part[i].emin <= s4_mag[i].emin;
        s5_part[i].den  <= s4_mag[i].den;
      end
      s5_xing <= s4_xing;
      s5_r2   <= s4_r2;

      for (int i = 0; i < 4; i++) begin
        s6_num[i] <= s5_part[i].perp ? sq[i] : NUMW'(s5_part[i].emin);
        s6_den[i] <= s5_part[i].perp ? s5_part[i].den : PW'(1);
      end
      s6_xing <= s5_xing;
      s6_r2   <= s5_r2;
    end
  end

  // squared distance scaled by 2^(2*FRAC_BITS), floored
  logic [XW-1:0] quo [4];
  logic          ovf [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    mcsh_div #(.QW(XW), .VW(PW)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (pv[6]),
      .dividend  (DVW'(s6_num[i]) << (2 * FRAC_BITS)),
      .divisor   (s6_den[i]),
      .out_valid (div_valid[i]),
      .quotient  (quo[i]),
      .overflow  (ovf[i])
    );
  end

  // side band alongside the divider: {crossing, radius nonzero, scaled radius squared}
  logic [XW+1:0] side_line [XW+1];
  logic [XW+1:0] side;
  logic [XW:0]   key   [4];
  logic          close [4];
  logic [XW:0]   s7_k01, s7_k23, s8_kmin;
  logic          s7_hit, s7_xing, s7_rnz, s8_hit, s8_xing, s8_rnz;

  assign side = side_line[XW];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key[i]   = {ovf[i], quo[i]};
      close[i] = !ovf[i] && (quo[i] < side[XW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_line[0] <= {s6_xing, s6_r2 != '0, XW'(s6_r2) << (2 * FRAC_BITS)};
      for (int k = 1; k <= XW; k++) begin
        side_line[k] <= side_line[k-1];
      end

      s7_k01  <= (key[0] < key[1]) ? key[0] : key[1];
      s7_k23  <= (key[2] < key[3]) ? key[2] : key[3];
      s7_hit  <= close[0] || close[1] || close[2] || close[3];
      s7_xing <= side[XW+1];
      s7_rnz  <= side[XW];

      s8_kmin <= (s7_k01 < s7_k23) ? s7_k01 : s7_k23;
      s8_hit  <= s7_hit;
      s8_xing <= s7_xing;
      s8_rnz  <= s7_rnz;
    end
  end

  logic           sq_valid;
  logic [SQW-1:0] root;

  mcsh_sqrt #(.XW(XW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (qv[1]),
    .radicand  (s8_kmin[XW-1:0]),
    .out_valid (sq_valid),
    .root      (root)
  );

  // side band alongside the root: {crossing, radius nonzero, hit, saturated}
  logic [3:0]           post_line [SQW+1];
  logic [3:0]           post;
  logic [DIST_BITS-1:0] dist_sat;

  assign post     = post_line[SQW];
  assign dist_sat = (post[0] || root > SQW'(DIST_MAX)) ? DIST_MAX : root[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      post_line[0] <= {s8_xing, s8_rnz, s8_hit, s8_kmin[XW]};
      for (int k = 1; k <= SQW; k++) begin
        post_line[k] <= post_line[k-1];
      end
      result.paths_cross  <= post[3];
      result.min_distance <= post[3] ? '0 : dist_sat;
      result.hit          <= post[3] ? post[2] : post[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= sq_valid;
    end
  end

  a_cross_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.paths_cross |-> result.min_distance == '0)
    else $error("crossing beat with nonzero distance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pv) && $stable(qv) && $stable(result_valid))
    else $error("pipeline moved while stalled");

  a_div_lanes: assert property (@(posedge clk) disable iff (rst)
    div_valid == 4'b0000 || div_valid == 4'b1111)
    else $error("divider lanes out of step");

endmodule

// ===== sim/moving_circle_segment_hit_core_tb.sv =====
// Testbench for the swept circle versus segment core: directed and random queries checked in order.
`timescale 1ns / 1ps

module moving_circle_segment_hit_core_tb;
  import mcsh_pkg::*;

  localparam int FRAC = 4;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic query_valid = 1'b0;
  logic query_stall;
  query_t query = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  result_t expected_results[$];
  int mismatches = 0;
  longint cycle_count = 0;
  bit long_hold = 1'b0;
  bit sink_idle_on = 1'b1;
  bit source_idle_on = 1'b1;

  moving_circle_segment_hit_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Squared distance from (px,py) to segment a-b as num/den (den 1 at endpoints).
  function automatic void point_to_segment(input longint ax, ay, bx, by, px, py,
                                           output logic [127:0] num, output logic [127:0] den);
    longint dx, dy, wx, wy, ex, ey, along_a, along_b, c, da, db;
    dx = bx - ax; dy = by - ay;
    wx = px - ax; wy = py - ay;
    ex = px - bx; ey = py - by;
    along_a = dx * wx + dy * wy;
    along_b = -(dx * ex + dy * ey);
    if (along_a > 0 && along_b > 0) begin
      c = dx * wy - dy * wx;
      if (c < 0) c = -c;
      num = 128'(c) * 128'(c);
      den = 128'(dx * dx + dy * dy);
    end else begin
      da = wx * wx + wy * wy;
      db = ex * ex + ey * ey;
      num = 128'(da < db ? da : db);
      den = 128'd1;
    end
  endfunction

  function automatic bit opposite_signs(input longint s, input longint t);
    return (s > 0 && t < 0) || (s < 0 && t > 0);
  endfunction

  function automatic result_t predict_sweep(input query_t q);
    result_t res;
    longint p0x, p0y, p1x, p1y, ax, ay, bx, by, mx, my, sx, sy, r;
    logic [127:0] num, den, target, t;
    logic [21:0] root;
    p0x = q.start_x; p0y = q.start_y;
    mx = q.move_x; my = q.move_y;
    p1x = p0x + mx; p1y = p0y + my;
    r = q.radius;
    ax = q.seg_a_x; ay = q.seg_a_y; bx = q.seg_b_x; by = q.seg_b_y;
    sx = bx - ax; sy = by - ay;
    res.paths_cross =
      opposite_signs(mx * (ay - p0y) - my * (ax - p0x), mx * (by - p0y) - my * (bx - p0x)) &&
      opposite_signs(sx * (p0y - ay) - sy * (p0x - ax), sx * (p1y - ay) - sy * (p1x - ax));
    res.min_distance = DIST_MAX;
    res.hit = 1'b0;
    if (res.paths_cross) begin
      res.min_distance = '0;
      res.hit = r > 0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: point_to_segment(p0x, p0y, p1x, p1y, ax, ay, num, den);
          1: point_to_segment(p0x, p0y, p1x, p1y, bx, by, num, den);
          2: point_to_segment(ax, ay, bx, by, p0x, p0y, num, den);
          default: point_to_segment(ax, ay, bx, by, p1x, p1y, num, den);
        endcase
        target = num << (2 * FRAC);
        root = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--) begin
          t = 128'(root | (22'd1 << b));
          if (t * t * den <= target) root[b] = 1'b1;
        end
        if (root < res.min_distance) res.min_distance = root;
        if (num < 128'(r * r) * den) res.hit = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Result side: random stall per beat, or a long hold-off when requested.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst) continue;
      if (long_hold) begin
        result_stall <= 1'b1;
        continue;
      end
      gap = sink_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0 && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat (gap - 1) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        result_t want;
        want = expected_results.pop_front();
        if (result.paths_cross !== want.paths_cross)
          report_mismatch("paths_cross", result.paths_cross, want.paths_cross);
        if (result.min_distance !== want.min_distance)
          report_mismatch("min_distance", result.min_distance, want.min_distance);
        if (result.hit !== want.hit) report_mismatch("hit", result.hit, want.hit);
      end
    end
  end

  task automatic send_query(input query_t q);
    int gap;
    gap = source_idle_on ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) != 0) gap = 0;
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1'b1;
    query <= q;
    do @(posedge clk); while (query_stall);
    expected_results.push_back(predict_sweep(q));
  endtask

  task automatic go_quiet();
    query_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic query_t make_query(input int sx, sy, mx, my, r, ax, ay, bx, by);
    query_t q;
    q.start_x = coord_t'(sx); q.start_y = coord_t'(sy);
    q.move_x = coord_t'(mx); q.move_y = coord_t'(my);
    q.radius = RAD_BITS'(r);
    q.seg_a_x = coord_t'(ax); q.seg_a_y = coord_t'(ay);
    q.seg_b_x = coord_t'(bx); q.seg_b_y = coord_t'(by);
    return q;
  endfunction

  task automatic test_directed();
    send_query(make_query(0, 0, 10, 10, 1, 0, 10, 10, 0));            // strict cross
    send_query(make_query(0, 0, 10, 10, 0, 0, 10, 10, 0));            // cross, no radius
    send_query(make_query(0, 0, 10, 0, 5, 10, 0, 10, 8));             // touching end
    send_query(make_query(0, 0, 10, 0, 3, 5, 0, 20, 0));              // collinear overlap
    send_query(make_query(0, 0, 10, 0, 3, 20, 0, 30, 0));             // collinear apart
    send_query(make_query(3, 4, 0, 0, 5, 0, 0, 0, 0));                // both points
    send_query(make_query(3, 4, 0, 0, 6, -10, 0, 10, 0));             // zero motion
    send_query(make_query(0, 5, 10, 0, 5, 5, 0, 5, 0));               // zero segment
    send_query(make_query(-32768, -32768, -32768, -32768, 32767,
                          32767, 32767, 32767, 32767));                 // far, below saturation
    send_query(make_query(32767, 32767, 32767, 32767, 32767,
                          -32768, -32768, -32768, 32767));
    send_query(make_query(-32768, 32767, 32767, -32768, 0,
                          -32768, -32768, 32767, 32767));
    send_query(make_query(0, 0, 100, 0, 7, 50, 7, 50, 30));           // equal to radius
    send_query(make_query(0, 0, 100, 0, 8, 50, 7, 50, 30));
    send_query(make_query(0, 0, 7, 3, 2, 1, 5, 9, 1));
    send_query(make_query(5, -5, -1, 2, 32767, -3, 0, 11, 0));
  endtask

  function automatic int rand_coord(input int spread);
    case ($urandom_range(0, 3))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                     : -32768 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 2 * spread)) - spread;
    endcase
  endfunction

  task automatic test_random(input int count);
    query_t q;
    int spread;
    for (int n = 0; n < count; n++) begin
      spread = $urandom_range(0, 1) ? 64 : 2000;
      q.start_x = coord_t'(rand_coord(spread)); q.start_y = coord_t'(rand_coord(spread));
      q.move_x = coord_t'(rand_coord(spread)); q.move_y = coord_t'(rand_coord(spread));
      q.radius = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, spread));
      q.seg_a_x = coord_t'(rand_coord(spread)); q.seg_a_y = coord_t'(rand_coord(spread));
      q.seg_b_x = $urandom_range(0, 7) == 0 ? q.seg_a_x : coord_t'(rand_coord(spread));
      q.seg_b_y = $urandom_range(0, 7) == 0 ? q.seg_a_y : coord_t'(rand_coord(spread));
      if ($urandom_range(0, 9) == 0) begin
        q.move_x = '0; q.move_y = '0;
      end
      send_query(q);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      test_random(150);
    join
    go_quiet();
  endtask

  task automatic test_full_rate();
    sink_idle_on = 1'b0;
    source_idle_on = 1'b0;
    test_random(150);
    go_quiet();
    sink_idle_on = 1'b1;
    source_idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    go_quiet();
    test_random(635);
    go_quiet();
    test_backpressure();
    test_full_rate();
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
